// ----- rtl/http_request_framer_macros.svh -----
// Assertion helpers for the request framer checker
`ifndef HTTP_REQUEST_FRAMER_MACROS_SVH
`define HTTP_REQUEST_FRAMER_MACROS_SVH

// same-cycle implication
`define HRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hrf_pkg.sv -----
`default_nettype none

package hrf_pkg;

    localparam int CFG_W      = 24;
    localparam int LEN_W      = 24;
    localparam int NAME_LEN   = 13;
    localparam int NAME_IDX_W = $clog2(NAME_LEN + 1);

    localparam logic [CFG_W-1:0] MAX_REQ_RESET = 24'd10485760;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [0:0] {
        CMD_DATA    = 1'b0,
        CMD_RESTART = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        SEC_METHOD  = 3'd0,
        SEC_URI     = 3'd1,
        SEC_VERSION = 3'd2,
        SEC_HNAME   = 3'd3,
        SEC_HVALUE  = 3'd4,
        SEC_BODY    = 3'd5,
        SEC_DELIM   = 3'd6
    } section_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_FIELDS    = 3'd1,
        ERR_NO_COLON  = 3'd2,
        ERR_SIZE      = 3'd3,
        ERR_BAD_LEN   = 3'd4
    } err_t;

    typedef struct packed {
        command_t   command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        section_t         section;
        status_t          status;
        err_t             error_code;
        logic [LEN_W-1:0] request_length;
        logic [LEN_W-1:0] body_length;
    } out_item_t;

    typedef logic [CFG_W-1:0] cfg_item_t;

    // "ContentLength"
    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h4C;
            4'd8:    ch = 8'h65;
            4'd9:    ch = 8'h6E;
            4'd10:   ch = 8'h67;
            4'd11:   ch = 8'h74;
            4'd12:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hrf_stream_if.sv -----
`default_nettype none

interface hrf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/http_request_framer.sv -----
// A result is registered and shown in the cycle after its input transfer.
// Throughput: one byte per cycle; the per-byte state update and the result
// register form a single stage, and a stalled result holds off new input.
// Reset (rst_n low, asynchronous): parser state cleared, failure cleared,
// max_request_bytes back to 10485760, no result pending.
`default_nettype none

module http_request_framer #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire           clk,
    input  wire           rst_n,
    hrf_stream_if.sink    request,
    hrf_stream_if.source  result,
    hrf_stream_if.sink    cfg
);

    localparam int LW    = hrf_pkg::LEN_W;
    localparam int CW    = hrf_pkg::CFG_W;
    localparam int IW    = hrf_pkg::NAME_IDX_W;
    localparam int XW    = COUNT_WIDTH + 4;
    localparam int CMP_W = (COUNT_WIDTH > CW) ? COUNT_WIDTH : CW;
    localparam logic [IW-1:0] NAME_END = IW'(hrf_pkg::NAME_LEN);

    typedef enum logic [1:0] {
        PH_LINE,
        PH_HEAD,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        CL_MID      = 2'd0,
        CL_MID_CR   = 2'd1,
        CL_START    = 2'd2,
        CL_START_CR = 2'd3
    } crlf_t;

    typedef enum logic [1:0] {
        DG_LEAD,
        DG_DIGITS,
        DG_TRAIL,
        DG_BAD
    } digit_t;

    phase_t                 phase_reg, phase_next;
    logic                   failed_reg, failed_next;
    hrf_pkg::err_t          fail_code_reg, fail_code_next;
    logic [COUNT_WIDTH-1:0] byte_count_reg, byte_count_next;
    crlf_t                  crlf_reg, crlf_next;
    logic [1:0]             space_reg, space_next;
    logic                   colon_reg, colon_next;
    logic [IW-1:0]          match_idx_reg, match_idx_next;
    logic                   matching_reg, matching_next;
    logic [COUNT_WIDTH-1:0] len_val_reg, len_val_next;
    logic                   len_present_reg, len_present_next;
    digit_t                 digit_reg, digit_next;
    logic [COUNT_WIDTH-1:0] body_rem_reg, body_rem_next;
    logic [CW-1:0]          max_bytes_reg, max_bytes_next;
    logic                   out_valid_reg, out_valid_next;
    hrf_pkg::out_item_t     out_item_reg, out_item_next;

    logic                   accept;
    logic [7:0]             ch;
    logic [COUNT_WIDTH-1:0] bc_inc;
    logic [COUNT_WIDTH-1:0] rem_dec;
    logic [XW-1:0]          len_acc;
    logic                   len_ovf;
    logic                   is_digit;
    logic                   is_blank;
    logic                   is_len_cur;
    logic                   is_len_w;
    logic                   done_w;
    logic                   clear_req;
    hrf_pkg::err_t          err_w;
    hrf_pkg::section_t      sec_w;
    hrf_pkg::status_t       stat_w;

    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_item_reg;

    assign ch       = request.payload.data_byte;
    assign bc_inc   = (&byte_count_reg) ? byte_count_reg
                                        : byte_count_reg + COUNT_WIDTH'(1);
    assign rem_dec  = (body_rem_reg != '0) ? body_rem_reg - COUNT_WIDTH'(1) : body_rem_reg;
    assign len_acc  = (XW'(len_val_reg) << 3) + (XW'(len_val_reg) << 1) + XW'(ch[3:0]);
    assign len_ovf  = |len_acc[XW-1:COUNT_WIDTH];
    assign is_digit = (ch >= hrf_pkg::CH_ZERO) && (ch <= hrf_pkg::CH_NINE);
    assign is_blank = (ch == hrf_pkg::CH_SP) || (ch == hrf_pkg::CH_TAB);
    assign is_len_cur = matching_reg && (match_idx_reg == NAME_END);

    always_comb
    begin
        phase_next       = phase_reg;
        failed_next      = failed_reg;
        fail_code_next   = fail_code_reg;
        byte_count_next  = byte_count_reg;
        crlf_next        = crlf_reg;
        space_next       = space_reg;
        colon_next       = colon_reg;
        match_idx_next   = match_idx_reg;
        matching_next    = matching_reg;
        len_val_next     = len_val_reg;
        len_present_next = len_present_reg;
        digit_next       = digit_reg;
        body_rem_next    = body_rem_reg;
        max_bytes_next   = cfg.valid ? cfg.payload : max_bytes_reg;
        out_valid_next   = accept || (out_valid_reg && !result.ready);
        out_item_next    = out_item_reg;

        sec_w     = hrf_pkg::SEC_DELIM;
        stat_w    = hrf_pkg::ST_BUSY;
        err_w     = hrf_pkg::ERR_NONE;
        done_w    = 1'b0;
        clear_req = 1'b0;
        is_len_w  = 1'b0;

        if (request.payload.command == hrf_pkg::CMD_RESTART)
        begin
            failed_next    = 1'b0;
            fail_code_next = hrf_pkg::ERR_NONE;
            clear_req      = 1'b1;
            sec_w          = hrf_pkg::SEC_METHOD;
        end
        else if (failed_reg)
        begin
            stat_w = hrf_pkg::ST_FAIL;
            err_w  = fail_code_reg;
        end
        else
        begin
            byte_count_next = bc_inc;
            unique case (phase_reg)
                PH_LINE:
                begin
                    if (ch == hrf_pkg::CH_CR)
                    begin
                        crlf_next = CL_MID_CR;
                    end
                    else if (ch == hrf_pkg::CH_LF && crlf_reg == CL_MID_CR)
                    begin
                        if (space_reg != 2'd2)
                        begin
                            err_w = hrf_pkg::ERR_FIELDS;
                        end
                        else
                        begin
                            phase_next     = PH_HEAD;
                            crlf_next      = CL_START;
                            colon_next     = 1'b0;
                            match_idx_next = '0;
                            matching_next  = 1'b1;
                            digit_next     = DG_LEAD;
                        end
                    end
                    else
                    begin
                        crlf_next = CL_MID;
                        if (ch == hrf_pkg::CH_SP)
                        begin
                            if (space_reg != 2'd3)
                            begin
                                space_next = space_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            sec_w = (space_reg == 2'd3) ? hrf_pkg::SEC_VERSION
                                                        : hrf_pkg::section_t'({1'b0, space_reg});
                        end
                    end
                end
                PH_HEAD:
                begin
                    // a CR not followed by LF is line content
                    if (crlf_reg[0] && ch != hrf_pkg::CH_LF)
                    begin
                        if (!colon_reg)
                        begin
                            matching_next = 1'b0;
                        end
                        else if (is_len_cur)
                        begin
                            digit_next = DG_BAD;
                        end
                    end

                    if (ch == hrf_pkg::CH_CR)
                    begin
                        crlf_next = crlf_reg[1] ? CL_START_CR : CL_MID_CR;
                    end
                    else if (ch == hrf_pkg::CH_LF && crlf_reg == CL_START_CR)
                    begin
                        if (len_present_reg && len_val_reg != '0)
                        begin
                            phase_next    = PH_BODY;
                            body_rem_next = len_val_reg;
                        end
                        else
                        begin
                            done_w = 1'b1;
                        end
                    end
                    else if (ch == hrf_pkg::CH_LF && crlf_reg == CL_MID_CR)
                    begin
                        if (!colon_reg)
                        begin
                            err_w = hrf_pkg::ERR_NO_COLON;
                        end
                        else if (is_len_cur && digit_reg != DG_DIGITS && digit_reg != DG_TRAIL)
                        begin
                            err_w = hrf_pkg::ERR_BAD_LEN;
                        end
                        else
                        begin
                            if (is_len_cur)
                            begin
                                len_present_next = 1'b1;
                            end
                            colon_next     = 1'b0;
                            match_idx_next = '0;
                            matching_next  = 1'b1;
                            digit_next     = DG_LEAD;
                            crlf_next      = CL_START;
                        end
                    end
                    else
                    begin
                        crlf_next = CL_MID;
                        is_len_w  = matching_next && (match_idx_next == NAME_END);
                        if (!colon_next)
                        begin
                            if (ch == hrf_pkg::CH_COLON)
                            begin
                                colon_next = 1'b1;
                                if (is_len_w)
                                begin
                                    len_val_next = '0;
                                    digit_next   = DG_LEAD;
                                end
                                sec_w = hrf_pkg::SEC_DELIM;
                            end
                            else
                            begin
                                if (matching_next)
                                begin
                                    if (match_idx_next != NAME_END &&
                                        ch == hrf_pkg::name_char(match_idx_next))
                                    begin
                                        match_idx_next = match_idx_next + IW'(1);
                                    end
                                    else
                                    begin
                                        matching_next = 1'b0;
                                    end
                                end
                                sec_w = hrf_pkg::SEC_HNAME;
                            end
                        end
                        else
                        begin
                            if (is_len_w)
                            begin
                                unique case (digit_next)
                                    DG_LEAD, DG_DIGITS:
                                    begin
                                        if (is_digit)
                                        begin
                                            if (len_ovf)
                                            begin
                                                digit_next = DG_BAD;
                                            end
                                            else
                                            begin
                                                len_val_next = len_acc[COUNT_WIDTH-1:0];
                                                digit_next   = DG_DIGITS;
                                            end
                                        end
                                        else if (is_blank)
                                        begin
                                            if (digit_next == DG_DIGITS)
                                            begin
                                                digit_next = DG_TRAIL;
                                            end
                                        end
                                        else
                                        begin
                                            digit_next = DG_BAD;
                                        end
                                    end
                                    DG_TRAIL:
                                    begin
                                        if (!is_blank)
                                        begin
                                            digit_next = DG_BAD;
                                        end
                                    end
                                    default:
                                    begin
                                        digit_next = DG_BAD;
                                    end
                                endcase
                            end
                            sec_w = hrf_pkg::SEC_HVALUE;
                        end
                    end
                end
                default:
                begin
                    sec_w         = hrf_pkg::SEC_BODY;
                    body_rem_next = rem_dec;
                    done_w        = (rem_dec == '0);
                end
            endcase

            if (err_w != hrf_pkg::ERR_NONE)
            begin
                failed_next    = 1'b1;
                fail_code_next = err_w;
                stat_w         = hrf_pkg::ST_FAIL;
            end
            else if (done_w)
            begin
                stat_w    = hrf_pkg::ST_DONE;
                clear_req = 1'b1;
            end
            else if (CMP_W'(bc_inc) >= CMP_W'(max_bytes_reg))
            begin
                err_w          = hrf_pkg::ERR_SIZE;
                failed_next    = 1'b1;
                fail_code_next = err_w;
                stat_w         = hrf_pkg::ST_FAIL;
            end
        end

        if (clear_req)
        begin
            phase_next       = PH_LINE;
            byte_count_next  = '0;
            crlf_next        = CL_MID;
            space_next       = 2'd0;
            colon_next       = 1'b0;
            match_idx_next   = '0;
            matching_next    = 1'b1;
            digit_next       = DG_LEAD;
            len_val_next     = '0;
            len_present_next = 1'b0;
            body_rem_next    = '0;
        end

        if (accept)
        begin
            out_item_next.section        = sec_w;
            out_item_next.status         = stat_w;
            out_item_next.error_code     = err_w;
            out_item_next.request_length = (stat_w == hrf_pkg::ST_DONE) ? LW'(bc_inc) : '0;
            out_item_next.body_length    = (stat_w == hrf_pkg::ST_DONE && len_present_reg)
                                           ? LW'(len_val_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LINE;
            failed_reg      <= 1'b0;
            fail_code_reg   <= hrf_pkg::ERR_NONE;
            byte_count_reg  <= '0;
            crlf_reg        <= CL_MID;
            space_reg       <= 2'd0;
            colon_reg       <= 1'b0;
            match_idx_reg   <= '0;
            matching_reg    <= 1'b1;
            len_val_reg     <= '0;
            len_present_reg <= 1'b0;
            digit_reg       <= DG_LEAD;
            body_rem_reg    <= '0;
            max_bytes_reg   <= hrf_pkg::MAX_REQ_RESET;
            out_valid_reg   <= 1'b0;
            out_item_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                failed_reg      <= failed_next;
                fail_code_reg   <= fail_code_next;
                byte_count_reg  <= byte_count_next;
                crlf_reg        <= crlf_next;
                space_reg       <= space_next;
                colon_reg       <= colon_next;
                match_idx_reg   <= match_idx_next;
                matching_reg    <= matching_next;
                len_val_reg     <= len_val_next;
                len_present_reg <= len_present_next;
                digit_reg       <= digit_next;
                body_rem_reg    <= body_rem_next;
            end
            max_bytes_reg <= max_bytes_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hrf_checker.sv -----
`default_nettype none
`include "http_request_framer_macros.svh"

module hrf_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_ready,
    input wire hrf_pkg::in_item_t  in_item,
    input wire                     out_valid,
    input wire                     out_ready,
    input wire hrf_pkg::out_item_t out_item
);

    `HRF_ASSERT_NXT(a_out_hold, clk, rst_n,
        out_valid && !out_ready,
        out_valid && $stable(out_item),
        "result changed while stalled")

    `HRF_ASSERT_IMP(a_len_only_done, clk, rst_n,
        out_valid && out_item.status != hrf_pkg::ST_DONE,
        out_item.request_length == '0 && out_item.body_length == '0,
        "lengths outside done")

    `HRF_ASSERT_IMP(a_err_iff_fail, clk, rst_n,
        out_valid,
        (out_item.status == hrf_pkg::ST_FAIL) == (out_item.error_code != hrf_pkg::ERR_NONE),
        "error code and status disagree")

    `HRF_ASSERT_NXT(a_restart_result, clk, rst_n,
        in_valid && in_ready && in_item.command == hrf_pkg::CMD_RESTART,
        out_valid && out_item.section == hrf_pkg::SEC_METHOD
            && out_item.status == hrf_pkg::ST_BUSY,
        "bad restart result")

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .in_item   (request.payload),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_item  (result.payload)
);

`default_nettype wire
